// File: rtl/sgf_pkg.sv
// Shared constants, types and control codes for the square-root gain fade block.
`timescale 1ns / 1ps

package sgf_pkg;

  localparam int SAMPLE_BITS    = 24;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int LEN_W          = 16;

  // Quotient m * 2^(2G) / n with m <= n is at most 2^(2G).
  localparam int DIV_STEPS  = 2 * GAIN_FRAC_BITS;
  localparam int QUOT_W     = DIV_STEPS + 1;
  // Root is at most 2^G, so G+1 result bits, one per step.
  localparam int SQRT_STEPS = GAIN_FRAC_BITS + 1;
  localparam int RAD_W      = 2 * SQRT_STEPS;
  localparam int ROOT_W     = SQRT_STEPS;
  localparam int SREM_W     = GAIN_FRAC_BITS + 2;
  localparam int PROD_W     = SAMPLE_BITS + ROOT_W + 1;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic REG_FADE_LENGTH    = 1'b0;
  localparam logic REG_FADE_DIRECTION = 1'b1;

  localparam logic [LEN_W-1:0] FADE_LENGTH_RST    = 16'd1024;
  localparam logic             FADE_DIRECTION_RST = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT_LOAD,
    ST_SQRT,
    ST_MUL,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic div_step;
    logic sqrt_load;
    logic sqrt_step;
    logic mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic sqrt_last;
  } status_t;

endpackage

// File: rtl/sgf_dp.sv
// Datapath: fade position, bit-serial divider, bit-serial square root, multiply and round.
`timescale 1ns / 1ps

module sgf_dp (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  sgf_pkg::cmd_t                        cmd_i,
  output sgf_pkg::status_t                     status_o,
  input  logic signed [sgf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                 first_i,
  input  logic [sgf_pkg::LEN_W-1:0]            fade_length_i,
  input  logic                                 fade_direction_i,
  output logic signed [sgf_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                 fade_done_o
);

  localparam int G = sgf_pkg::GAIN_FRAC_BITS;
  localparam logic signed [sgf_pkg::PROD_W-1:0] HALF_LSB =
    sgf_pkg::PROD_W'(1) << (G - 1);

  logic [sgf_pkg::LEN_W-1:0]  pos_q, pos_d;
  logic [sgf_pkg::STEP_W-1:0] cnt_q, cnt_d;

  logic [sgf_pkg::LEN_W-1:0]  n_q;
  logic [sgf_pkg::LEN_W-1:0]  rem_q;
  logic [sgf_pkg::QUOT_W-1:0] quot_q;
  logic [sgf_pkg::RAD_W-1:0]  rad_q;
  logic [sgf_pkg::SREM_W-1:0] srem_q;
  logic [sgf_pkg::ROOT_W-1:0] root_q;
  logic signed [sgf_pkg::SAMPLE_BITS-1:0] sample_q;
  logic signed [sgf_pkg::PROD_W-1:0]      prod_q;
  logic done_q;
  logic signed [sgf_pkg::SAMPLE_BITS-1:0] out_sample_q;
  logic out_done_q;

  logic [sgf_pkg::LEN_W-1:0]  n_eff, k_eff, m_val;
  logic [sgf_pkg::LEN_W:0]    k_next;
  logic                       done_now, m_full;
  logic [sgf_pkg::LEN_W:0]    rem_sh, rem_sub;
  logic                       div_ge;
  logic [sgf_pkg::SREM_W+1:0] srem_ext, trial, srem_sub;
  logic                       sqrt_ge;
  logic signed [sgf_pkg::ROOT_W:0]   gain_s;
  logic signed [sgf_pkg::PROD_W-1:0] prod_rnd, prod_sh;

  // Position of this item; a stale position at or past the length restarts the fade.
  always_comb begin
    n_eff    = (fade_length_i == '0) ? sgf_pkg::LEN_W'(1) : fade_length_i;
    k_eff    = (first_i || (pos_q >= n_eff)) ? '0 : pos_q;
    k_next   = {1'b0, k_eff} + (sgf_pkg::LEN_W + 1)'(1);
    done_now = (k_next == {1'b0, n_eff});
    m_val    = fade_direction_i ? k_eff : (n_eff - k_eff);
    m_full   = (m_val == n_eff);
  end

  // One quotient bit per step.
  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    rem_sub = rem_sh - {1'b0, n_q};
    div_ge  = (rem_sh >= {1'b0, n_q});
  end

  // One root bit per step, two radicand bits consumed.
  always_comb begin
    srem_ext = {srem_q, rad_q[sgf_pkg::RAD_W-1 -: 2]};
    trial    = {1'b0, root_q, 2'b01};
    srem_sub = srem_ext - trial;
    sqrt_ge  = (srem_ext >= trial);
  end

  always_comb begin
    gain_s   = $signed({1'b0, root_q});
    prod_rnd = prod_q + HALF_LSB;
    prod_sh  = prod_rnd >>> G;
  end

  always_comb begin
    pos_d = pos_q;
    if (cmd_i.load) begin
      pos_d = done_now ? '0 : k_next[sgf_pkg::LEN_W-1:0];
    end
    cnt_d = cnt_q;
    if (cmd_i.load || cmd_i.sqrt_load) begin
      cnt_d = '0;
    end else if (cmd_i.div_step || cmd_i.sqrt_step) begin
      cnt_d = cnt_q + sgf_pkg::STEP_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      n_q      <= n_eff;
      sample_q <= sample_in_i;
      done_q   <= done_now;
      // Integer part of m/n is 1 only when m == n; remainder is then zero.
      rem_q    <= m_full ? '0 : m_val;
      quot_q   <= sgf_pkg::QUOT_W'(m_full);
    end else if (cmd_i.div_step) begin
      rem_q  <= div_ge ? rem_sub[sgf_pkg::LEN_W-1:0] : rem_sh[sgf_pkg::LEN_W-1:0];
      quot_q <= {quot_q[sgf_pkg::QUOT_W-2:0], div_ge};
    end
    if (cmd_i.sqrt_load) begin
      rad_q  <= sgf_pkg::RAD_W'(quot_q);
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= {rad_q[sgf_pkg::RAD_W-3:0], 2'b00};
      srem_q <= sqrt_ge ? srem_sub[sgf_pkg::SREM_W-1:0] : srem_ext[sgf_pkg::SREM_W-1:0];
      root_q <= {root_q[sgf_pkg::ROOT_W-2:0], sqrt_ge};
    end
    if (cmd_i.mul) begin
      prod_q <= sample_q * gain_s;
    end
    if (cmd_i.out_load) begin
      out_sample_q <= prod_sh[sgf_pkg::SAMPLE_BITS-1:0];
      out_done_q   <= done_q;
    end
  end

  assign status_o.div_last  = (cnt_q == sgf_pkg::STEP_W'(sgf_pkg::DIV_STEPS - 1));
  assign status_o.sqrt_last = (cnt_q == sgf_pkg::STEP_W'(sgf_pkg::SQRT_STEPS - 1));
  assign sample_out_o = out_sample_q;
  assign fade_done_o  = out_done_q;

endmodule

// File: rtl/sgf_ctrl.sv
// Controller: sequences one item through divide, square root, multiply and output.
`timescale 1ns / 1ps

module sgf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  sgf_pkg::status_t  status_i,
  output sgf_pkg::cmd_t     cmd_o
);

  sgf_pkg::state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      sgf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = sgf_pkg::ST_DIV;
        end
      end
      sgf_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = sgf_pkg::ST_SQRT_LOAD;
        end
      end
      sgf_pkg::ST_SQRT_LOAD: begin
        cmd_o.sqrt_load = 1'b1;
        state_d         = sgf_pkg::ST_SQRT;
      end
      sgf_pkg::ST_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        if (status_i.sqrt_last) begin
          state_d = sgf_pkg::ST_MUL;
        end
      end
      sgf_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = sgf_pkg::ST_FINISH;
      end
      sgf_pkg::ST_FINISH: begin
        // Hold until the output register is free or being drained.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = sgf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sgf_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sgf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |-> (!out_valid_q || out_ready_i))
    else $error("result register overwritten before it was taken");

  a_busy_not_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != sgf_pkg::ST_IDLE) |-> !in_ready_o)
    else $error("item accepted while another is in progress");

  a_accept_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !cmd_o.out_load)
    else $error("result produced right after accept");

  a_sqrt_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sgf_pkg::ST_SQRT && status_i.sqrt_last) |=> (state_q == sgf_pkg::ST_MUL))
    else $error("square root did not hand over to multiply");

  a_load_clears_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> (state_q == sgf_pkg::ST_DIV && !status_i.div_last))
    else $error("divider step count not restarted");

endmodule

// File: rtl/sqrt_gain_fade_core.sv
// Top level: APB configuration registers, controller and datapath of the gain fade.
`timescale 1ns / 1ps

// Square-root gain fade. Each sample is scaled by floor(sqrt(floor(m*2^32/n)))/2^16,
// with m the fade position (fade in) or n minus it (fade out), and rounded to nearest.
// One item is processed at a time, from accept to result: the accept step, the
// bit-serial divider (one quotient bit per cycle), the square-root load step, the
// bit-serial square root (one root bit per cycle), the multiply step and the
// round-and-output step. A finished result waits in the output register while the
// next item is accepted; the result stage holds only when that register is still
// full. Registers: fade_length at 0x0 (0 behaves as 1), fade_direction at 0x4
// (1 fade in, 0 fade out); write them only while the block is idle.
module sqrt_gain_fade_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [sgf_pkg::ADDR_W-1:0]             paddr,
  input  logic [sgf_pkg::DATA_W-1:0]             pwdata,
  output logic [sgf_pkg::DATA_W-1:0]             prdata,
  output logic                                   pready,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic signed [sgf_pkg::SAMPLE_BITS-1:0] sample_in_i,
  input  logic                                   first_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [sgf_pkg::SAMPLE_BITS-1:0] sample_out_o,
  output logic                                   fade_done_o
);

  logic [sgf_pkg::LEN_W-1:0] fade_length_q, fade_length_d;
  logic                      fade_direction_q, fade_direction_d;
  logic                      reg_sel;
  logic                      wr_en;

  sgf_pkg::cmd_t    cmd;
  sgf_pkg::status_t status;

  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    fade_length_d    = fade_length_q;
    fade_direction_d = fade_direction_q;
    if (wr_en) begin
      if (reg_sel == sgf_pkg::REG_FADE_LENGTH) begin
        fade_length_d = pwdata[sgf_pkg::LEN_W-1:0];
      end else begin
        fade_direction_d = pwdata[0];
      end
    end
  end

  always_comb begin
    if (reg_sel == sgf_pkg::REG_FADE_DIRECTION) begin
      prdata = sgf_pkg::DATA_W'(fade_direction_q);
    end else begin
      prdata = sgf_pkg::DATA_W'(fade_length_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fade_length_q    <= sgf_pkg::FADE_LENGTH_RST;
      fade_direction_q <= sgf_pkg::FADE_DIRECTION_RST;
    end else begin
      fade_length_q    <= fade_length_d;
      fade_direction_q <= fade_direction_d;
    end
  end

  sgf_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  sgf_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .sample_in_i      (sample_in_i),
    .first_i          (first_i),
    .fade_length_i    (fade_length_q),
    .fade_direction_i (fade_direction_q),
    .sample_out_o     (sample_out_o),
    .fade_done_o      (fade_done_o)
  );

endmodule
